// File: sv/fssv_pkg.sv
`timescale 1ns / 1ps
// fssv_pkg: status codes, on-disk constants and the result record of the
// superblock validator. No dependencies.

package fssv_pkg;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_IO      = 3'd1,
    ST_V1      = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_INVALID = 3'd4
  } fssv_status_e;

  localparam logic [15:0] MAGIC_V2    = 16'h2468;
  localparam logic [15:0] MAGIC_V2_SW = 16'h6824;
  localparam logic [15:0] MAGIC_V1    = 16'h137f;
  localparam logic [15:0] MAGIC_V1_SW = 16'h7f13;

  localparam logic [31:0] MIN_CAPACITY   = 32'd2048;
  localparam logic [15:0] MAP_BLOCKS_MAX = 16'd32767;
  localparam logic [15:0] LOG_ZONE_MAX   = 16'd4;
  localparam int unsigned BLOCK_LOG2            = 10;
  localparam int unsigned MAP_BITS_LOG2         = 13;
  localparam int unsigned INODES_PER_BLOCK_LOG2 = 4;
  localparam logic [16:0] INODES_PER_BLOCK_M1   = 17'd15;

  typedef struct packed {
    fssv_status_e status;
    logic         byte_swapped;
    logic [15:0]  inode_count;
    logic [14:0]  inode_map_blocks;
    logic [14:0]  zone_map_blocks;
    logic [15:0]  data_zone_start;
    logic [2:0]   zone_size_log;
    logic [30:0]  max_file_size;
    logic [31:0]  zone_count;
  } fssv_result_t;

endpackage

// File: sv/fssv_in_if.sv
`timescale 1ns / 1ps
// fssv_in_if: valid/ready channel carrying the superblock words.
// No dependencies.

interface fssv_in_if;
  logic        valid;
  logic        ready;
  logic        read_complete;
  logic [63:0] sb_bytes_low;
  logic [63:0] sb_bytes_mid;
  logic [63:0] sb_bytes_high;

  modport source (
    output valid, read_complete, sb_bytes_low, sb_bytes_mid, sb_bytes_high,
    input  ready
  );
  modport sink (
    input  valid, read_complete, sb_bytes_low, sb_bytes_mid, sb_bytes_high,
    output ready
  );
endinterface

// File: sv/fssv_out_if.sv
`timescale 1ns / 1ps
// fssv_out_if: valid/ready channel carrying the validation result.
// No dependencies.

interface fssv_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        byte_swapped;
  logic [15:0] inode_count;
  logic [14:0] inode_map_blocks;
  logic [14:0] zone_map_blocks;
  logic [15:0] data_zone_start;
  logic [2:0]  zone_size_log;
  logic [30:0] max_file_size;
  logic [31:0] zone_count;

  modport source (
    output valid, status, byte_swapped, inode_count, inode_map_blocks,
           zone_map_blocks, data_zone_start, zone_size_log, max_file_size,
           zone_count,
    input  ready
  );
  modport sink (
    input  valid, status, byte_swapped, inode_count, inode_map_blocks,
           zone_map_blocks, data_zone_start, zone_size_log, max_file_size,
           zone_count,
    output ready
  );
endinterface

// File: sv/fssv_check.sv
`timescale 1ns / 1ps
// fssv_check: decodes the superblock fields and runs all validity checks.
// Depends on fssv_pkg.

module fssv_check import fssv_pkg::*; (
  input  logic [31:0]  capacity_i,
  input  logic         read_complete_i,
  input  logic [63:0]  sb_low_i,
  input  logic [63:0]  sb_mid_i,
  input  logic [63:0]  sb_high_i,
  output fssv_result_t result_o
);

  function automatic logic [15:0] order16(input logic [15:0] x, input logic sw);
    order16 = sw ? {x[7:0], x[15:8]} : x;
  endfunction

  function automatic logic [31:0] order32(input logic [31:0] x, input logic sw);
    order32 = sw ? {x[7:0], x[15:8], x[23:16], x[31:24]} : x;
  endfunction

  logic [15:0] magic;
  logic        sw;
  logic [15:0] ninodes, imap, zmap, fdz, lzs;
  logic [31:0] maxsz, zones;
  logic [2:0]  lzs_sh;
  logic [21:0] zone_bound;
  logic [16:0] ino_blocks;
  logic [17:0] meta;
  logic [19:0] fdz_blocks;
  logic [28:0] imap_bits, zmap_bits;
  logic [16:0] ninodes_p1;
  logic [32:0] zone_span;
  logic        basic_bad, range_bad, space_bad;

  always_comb begin
    magic   = sb_high_i[15:0];
    sw      = (magic == MAGIC_V2_SW);
    ninodes = order16(sb_low_i[15:0], sw);
    imap    = order16(sb_low_i[47:32], sw);
    zmap    = order16(sb_low_i[63:48], sw);
    fdz     = order16(sb_mid_i[15:0], sw);
    lzs     = order16(sb_mid_i[31:16], sw);
    maxsz   = order32(sb_mid_i[63:32], sw);
    zones   = order32(sb_high_i[63:32], sw);
    lzs_sh  = lzs[2:0];

    basic_bad = (ninodes == '0) || (imap == '0) || (zmap == '0) ||
                (imap > MAP_BLOCKS_MAX) || (zmap > MAP_BLOCKS_MAX) ||
                (lzs > LOG_ZONE_MAX) || (maxsz == '0) || maxsz[31];

    zone_bound = capacity_i[31:BLOCK_LOG2] >> lzs_sh;
    range_bad  = (zones > {10'd0, zone_bound}) || ({16'd0, fdz} >= zones);

    ninodes_p1 = {1'b0, ninodes} + 17'd1;
    ino_blocks = ({1'b0, ninodes} + INODES_PER_BLOCK_M1) >> INODES_PER_BLOCK_LOG2;
    meta       = 18'd2 + {2'd0, imap} + {2'd0, zmap} + {1'b0, ino_blocks};
    fdz_blocks = {4'd0, fdz} << lzs_sh;
    imap_bits  = {13'd0, imap} << MAP_BITS_LOG2;
    zmap_bits  = {13'd0, zmap} << MAP_BITS_LOG2;
    zone_span  = {1'b0, zones} - {17'd0, fdz} + 33'd1;
    space_bad  = ({2'd0, meta} > fdz_blocks) ||
                 ({12'd0, ninodes_p1} > imap_bits) ||
                 (zone_span > {4'd0, zmap_bits});

    result_o = '0;
    if (capacity_i < MIN_CAPACITY) begin
      result_o.status = ST_INVALID;
    end else if (!read_complete_i) begin
      result_o.status = ST_IO;
    end else if (magic == MAGIC_V1 || magic == MAGIC_V1_SW) begin
      result_o.status = ST_V1;
    end else if (magic != MAGIC_V2 && magic != MAGIC_V2_SW) begin
      result_o.status = ST_ABSENT;
    end else if (basic_bad || range_bad || space_bad) begin
      result_o.status = ST_INVALID;
    end else begin
      result_o.status           = ST_OK;
      result_o.byte_swapped     = sw;
      result_o.inode_count      = ninodes;
      result_o.inode_map_blocks = imap[14:0];
      result_o.zone_map_blocks  = zmap[14:0];
      result_o.data_zone_start  = fdz;
      result_o.zone_size_log    = lzs_sh;
      result_o.max_file_size    = maxsz[30:0];
      result_o.zone_count       = zones;
    end
  end

endmodule

// File: sv/fs_superblock_validator_unit.sv
`timescale 1ns / 1ps
// fs_superblock_validator_unit: top level of the superblock validator.
// Depends on fssv_pkg, fssv_in_if, fssv_out_if and fssv_check.
//
//   channel   direction  handshake      carries
//   sb_i      in         valid/ready    read_complete, three 64-bit sb words
//   res_o     out        valid/ready    status, byte_swapped, decoded fields
//   cfg       in         cfg_we_i       disk capacity in bytes
//
// An accepted item passes through one input register, the checks and the
// result register; result valid rises when the item is loaded into the latter.
// One item per cycle is sustained while res_o.ready is high; a stalled result
// holds in the result register while the input register still takes one more item.
// Reset clears the valid flags and sets the capacity to zero.

module fs_superblock_validator_unit import fssv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  fssv_in_if.sink     sb_i,
  fssv_out_if.source  res_o
);

  logic [31:0]  capacity_q;
  logic         s1_valid_q, s1_valid_d;
  logic         s1_rc_q;
  logic [63:0]  s1_low_q, s1_mid_q, s1_high_q;
  logic         res_valid_q, res_valid_d;
  fssv_result_t res_q, check_res;
  logic         in_xfer, s1_advance;

  assign s1_advance = !res_valid_q || res_o.ready;
  assign sb_i.ready = !s1_valid_q || s1_advance;
  assign in_xfer    = sb_i.valid && sb_i.ready;
  assign s1_valid_d = in_xfer || (s1_valid_q && !s1_advance);
  assign res_valid_d = s1_advance ? s1_valid_q : res_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= '0;
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_rc_q   <= sb_i.read_complete;
      s1_low_q  <= sb_i.sb_bytes_low;
      s1_mid_q  <= sb_i.sb_bytes_mid;
      s1_high_q <= sb_i.sb_bytes_high;
    end
    if (s1_advance && s1_valid_q) begin
      res_q <= check_res;
    end
  end

  fssv_check u_check (
    .capacity_i      (capacity_q),
    .read_complete_i (s1_rc_q),
    .sb_low_i        (s1_low_q),
    .sb_mid_i        (s1_mid_q),
    .sb_high_i       (s1_high_q),
    .result_o        (check_res)
  );

  assign res_o.valid            = res_valid_q;
  assign res_o.status           = res_q.status;
  assign res_o.byte_swapped     = res_q.byte_swapped;
  assign res_o.inode_count      = res_q.inode_count;
  assign res_o.inode_map_blocks = res_q.inode_map_blocks;
  assign res_o.zone_map_blocks  = res_q.zone_map_blocks;
  assign res_o.data_zone_start  = res_q.data_zone_start;
  assign res_o.zone_size_log    = res_q.zone_size_log;
  assign res_o.max_file_size    = res_q.max_file_size;
  assign res_o.zone_count       = res_q.zone_count;

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.status != ST_OK |->
      !res_q.byte_swapped && res_q.inode_count == '0 && res_q.zone_count == '0 &&
      res_q.max_file_size == '0 && res_q.data_zone_start == '0)
    else $error("failed result carries nonzero fields");

  a_ok_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.status == ST_OK |->
      res_q.inode_count != '0 && res_q.zone_size_log <= 3'd4 &&
      res_q.inode_map_blocks != '0 && res_q.zone_map_blocks != '0)
    else $error("accepted superblock with out-of-range fields");

  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> s1_valid_q)
    else $error("transferred item not held in input stage");

endmodule
